[rtl/nns_pkg.sv]
package nns_pkg;

  localparam int PIX_W      = 32;
  localparam int COORD_W    = 12;
  localparam int DIM_W      = 9;
  localparam int SCALE_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int PTR_W      = 17;
  localparam int SRC_OUT_W  = 8;
  localparam int IDX_W      = 2 * DIM_W;

  localparam logic [DIM_W-1:0]   RST_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0]   RST_HEIGHT = 9'd256;
  localparam logic [SCALE_W-1:0] RST_SCALE  = 16'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q    = 2'd2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef struct packed {
    logic load;
    logic capture;
    logic bound;
    logic div_start;
    logic index;
    logic read;
    logic respond;
  } nns_cmd_t;

  typedef struct packed {
    logic ok;
    logic div_done;
  } nns_status_t;

endpackage

[rtl/nns_div.sv]
module nns_div import nns_pkg::*; #(
  parameter int DW = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DW-1:0]      dividend_i,
  input  logic [SCALE_W-1:0] divisor_i,
  output logic [DW-1:0]      quotient_o,
  output logic               done_o
);

  localparam int CW = $clog2(DW);
  localparam logic [CW-1:0] LAST = CW'(DW - 1);

  logic [DW-1:0]      quo_q;
  logic [SCALE_W-1:0] rem_q;
  logic [SCALE_W-1:0] dvs_q;
  logic [CW-1:0]      cnt_q;
  logic               run_q;
  logic [SCALE_W:0]   rem_sh;
  logic [SCALE_W:0]   rem_diff;
  logic               ge;

  always_comb begin
    rem_sh   = {rem_q, quo_q[DW-1]};
    rem_diff = rem_sh - {1'b0, dvs_q};
    ge       = rem_sh >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= ge ? rem_diff[SCALE_W-1:0] : rem_sh[SCALE_W-1:0];
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = run_q && (cnt_q == LAST);

endmodule

[rtl/nns_datapath.sv]
module nns_datapath import nns_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [PIX_W-1:0]      pixel_in_i,
  input  logic [COORD_W-1:0]    out_x_i,
  input  logic [COORD_W-1:0]    out_y_i,
  input  nns_cmd_t              cmd_i,
  output nns_status_t           status_o,
  output logic [PIX_W-1:0]      pixel_out_o,
  output logic [SRC_OUT_W-1:0]  src_x_o,
  output logic [SRC_OUT_W-1:0]  src_y_o,
  output logic                  in_range_o
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW     = COORD_W + FRAC_BITS;
  localparam int PROD_W = DIM_W + SCALE_W;

  logic [DIM_W-1:0]   cfg_w_q;
  logic [DIM_W-1:0]   cfg_h_q;
  logic [SCALE_W-1:0] scale_q;
  logic [PTR_W-1:0]   ptr_q;

  logic [COORD_W-1:0] ox_q;
  logic [COORD_W-1:0] oy_q;
  logic               ok_q;
  logic [DIM_W-1:0]   sx_q;
  logic [DIM_W-1:0]   sy_q;
  logic [IDX_W-1:0]   idx_q;
  logic               idx_ok_q;
  logic [PIX_W-1:0]   rdata_q;

  logic [PIX_W-1:0]     pixel_out_q;
  logic [SRC_OUT_W-1:0] src_x_q;
  logic [SRC_OUT_W-1:0] src_y_q;
  logic                 in_range_q;

  logic [PIX_W-1:0] mem [DEPTH];

  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [IDX_W-1:0]  total;
  logic              load_ok;
  logic [PROD_W-1:0] prod_w;
  logic [PROD_W-1:0] prod_h;
  logic              ok_d;
  logic [DW-1:0]     quo_x;
  logic [DW-1:0]     quo_y;
  logic              done_x;
  logic              done_y;
  logic [DIM_W-1:0]  sx_c;
  logic [DIM_W-1:0]  sy_c;

  always_comb begin
    w_eff   = (int'(cfg_w_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : cfg_w_q;
    h_eff   = (int'(cfg_h_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : cfg_h_q;
    total   = IDX_W'(w_eff) * IDX_W'(h_eff);
    load_ok = (IDX_W'(ptr_q) < total) && (int'(ptr_q) < DEPTH);
    prod_w  = PROD_W'(w_eff) * PROD_W'(scale_q);
    prod_h  = PROD_W'(h_eff) * PROD_W'(scale_q);
    ok_d    = (scale_q != '0) && (PROD_W'(ox_q) < (prod_w >> FRAC_BITS))
              && (PROD_W'(oy_q) < (prod_h >> FRAC_BITS));
    sx_c    = (quo_x >= DW'(w_eff)) ? w_eff - 1'b1 : quo_x[DIM_W-1:0];
    sy_c    = (quo_y >= DW'(h_eff)) ? h_eff - 1'b1 : quo_y[DIM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= RST_WIDTH;
      cfg_h_q <= RST_HEIGHT;
      scale_q <= RST_SCALE;
      ptr_q   <= '0;
      ok_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SRC_WIDTH:  cfg_w_q <= cfg_data_i[DIM_W-1:0];
          CFG_SRC_HEIGHT: cfg_h_q <= cfg_data_i[DIM_W-1:0];
          CFG_SCALE_Q:    scale_q <= cfg_data_i[SCALE_W-1:0];
          default:        ;
        endcase
      end
      if (cmd_i.load && load_ok) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.bound) begin
        ok_q <= ok_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_ok) begin
      mem[AW'(ptr_q)] <= pixel_in_i;
    end
    if (cmd_i.read) begin
      rdata_q <= mem[AW'(idx_q)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ox_q <= out_x_i;
      oy_q <= out_y_i;
    end
    if (cmd_i.index) begin
      sx_q  <= sx_c;
      sy_q  <= sy_c;
      idx_q <= IDX_W'(sy_c) * IDX_W'(w_eff) + IDX_W'(sx_c);
    end
    if (cmd_i.read) begin
      idx_ok_q <= int'(idx_q) < DEPTH;
    end
    if (cmd_i.respond) begin
      pixel_out_q <= (ok_q && idx_ok_q) ? rdata_q : '0;
      src_x_q     <= ok_q ? SRC_OUT_W'(sx_q) : '0;
      src_y_q     <= ok_q ? SRC_OUT_W'(sy_q) : '0;
      in_range_q  <= ok_q;
    end
  end

  nns_div #(.DW(DW)) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({ox_q, {FRAC_BITS{1'b0}}}),
    .divisor_i  (scale_q),
    .quotient_o (quo_x),
    .done_o     (done_x)
  );

  nns_div #(.DW(DW)) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({oy_q, {FRAC_BITS{1'b0}}}),
    .divisor_i  (scale_q),
    .quotient_o (quo_y),
    .done_o     (done_y)
  );

  assign status_o.ok       = ok_q;
  assign status_o.div_done = done_x && done_y;

  assign pixel_out_o = pixel_out_q;
  assign src_x_o     = src_x_q;
  assign src_y_o     = src_y_q;
  assign in_range_o  = in_range_q;

endmodule

[rtl/nns_ctrl.sv]
module nns_ctrl import nns_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        opcode_i,
  input  nns_status_t status_i,
  output nns_cmd_t    cmd_o,
  output logic        busy_o,
  output logic        done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BOUND,
    S_CHECK,
    S_DIV,
    S_INDEX,
    S_READ,
    S_RESP
  } state_e;

  state_e state_q;
  logic   done_q;
  logic   accept;

  assign accept = start_i && (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept && opcode_i == OP_READ) begin
            state_q <= S_BOUND;
          end
        end
        S_BOUND: state_q <= S_CHECK;
        S_CHECK: state_q <= status_i.ok ? S_DIV : S_RESP;
        S_DIV: begin
          if (status_i.div_done) begin
            state_q <= S_INDEX;
          end
        end
        S_INDEX: state_q <= S_READ;
        S_READ:  state_q <= S_RESP;
        S_RESP: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept && (opcode_i == OP_LOAD);
    cmd_o.capture   = accept && (opcode_i == OP_READ);
    cmd_o.bound     = state_q == S_BOUND;
    cmd_o.div_start = (state_q == S_CHECK) && status_i.ok;
    cmd_o.index     = state_q == S_INDEX;
    cmd_o.read      = state_q == S_READ;
    cmd_o.respond   = state_q == S_RESP;
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = done_q;

endmodule

[rtl/nearest_neighbor_image_scaler.sv]
// Nearest-neighbor frame-buffer scaler.
// Requests enter on start while busy is low; opcode_i selects a load or a read.
// A load writes pixel_in_i at the next raster position until the frame is full
// and gives no result; busy stays low, so loads may follow each other every cycle.
// A read of (out_x_i, out_y_i) returns one result marked by done_o for exactly
// one cycle: pixel_out_o, src_x_o, src_y_o and in_range_o.
// In-range reads pass through two restoring dividers that retire one quotient
// bit per cycle; out-of-range reads skip the dividers and go straight to the response.
// The next request may be issued in the cycle that done_o is high.
// The receiver cannot stall: done_o marks each result once and is not held.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle:
// index 0 source width, 1 source height, 2 scale factor (FRAC_BITS fraction bits).
// Reset restores width 256, height 256, scale 4096 (1.0 at the default FRAC_BITS)
// and rewinds the load position; the pixel store is undefined until loaded.
module nearest_neighbor_image_scaler import nns_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  start,
  output logic                  busy,
  input  logic                  opcode_i,
  input  logic [PIX_W-1:0]      pixel_in_i,
  input  logic [COORD_W-1:0]    out_x_i,
  input  logic [COORD_W-1:0]    out_y_i,
  output logic                  done_o,
  output logic [PIX_W-1:0]      pixel_out_o,
  output logic [SRC_OUT_W-1:0]  src_x_o,
  output logic [SRC_OUT_W-1:0]  src_y_o,
  output logic                  in_range_o
);

  nns_cmd_t    cmd;
  nns_status_t status;

  nns_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (opcode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  nns_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_in_i  (pixel_in_i),
    .out_x_i     (out_x_i),
    .out_y_i     (out_y_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .pixel_out_o (pixel_out_o),
    .src_x_o     (src_x_o),
    .src_y_o     (src_y_o),
    .in_range_o  (in_range_o)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == OP_READ) |=> busy)
    else $error("read request did not start work");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == OP_LOAD) |=> (!busy && !done_o))
    else $error("load request produced work or a result");

  a_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !in_range_o) |-> (pixel_out_o == '0 && src_x_o == '0 && src_y_o == '0))
    else $error("out-of-range result not zero");

endmodule

[tb/tb.sv]
module tb;
  import nns_pkg::*;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int FRAC_BITS    = 12;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE       = 8;
  localparam int DRAIN_CYCLES = 40;
  localparam int SEGMENTS     = 6;
  localparam int FILL_MAX     = 32;
  localparam int MIXED_ITEMS  = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [COORD_W-1:0]   COORD_FAR  = '1;
  localparam logic [SCALE_W-1:0]   SCALE_ONE  = 16'd4096;

  typedef struct packed {
    logic [PIX_W-1:0]     pixel;
    logic [SRC_OUT_W-1:0] sx;
    logic [SRC_OUT_W-1:0] sy;
    logic                 in_range;
  } sample_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  start;
  logic                  busy;
  logic                  opcode_i;
  logic [PIX_W-1:0]      pixel_in_i;
  logic [COORD_W-1:0]    out_x_i;
  logic [COORD_W-1:0]    out_y_i;
  logic                  done_o;
  logic [PIX_W-1:0]      pixel_out_o;
  logic [SRC_OUT_W-1:0]  src_x_o;
  logic [SRC_OUT_W-1:0]  src_y_o;
  logic                  in_range_o;

  sample_t          expected_samples[$];
  bit [PIX_W-1:0]   frame_mem [MAX_WIDTH*MAX_HEIGHT];
  int               frame_ptr;
  int               width_reg;
  int               height_reg;
  int               scale_reg;
  int               err_count;
  int               cycle_count;
  int               gap_pct;

  nearest_neighbor_image_scaler #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start      (start),
    .busy       (busy),
    .opcode_i   (opcode_i),
    .pixel_in_i (pixel_in_i),
    .out_x_i    (out_x_i),
    .out_y_i    (out_y_i),
    .done_o     (done_o),
    .pixel_out_o(pixel_out_o),
    .src_x_o    (src_x_o),
    .src_y_o    (src_y_o),
    .in_range_o (in_range_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  always @(posedge clk_i) begin : check_results
    sample_t want;
    if (rst_ni && done_o) begin
      if (expected_samples.size() == 0) begin
        flag_mismatch("result with no read outstanding");
      end else begin
        want = expected_samples.pop_front();
        if (pixel_out_o !== want.pixel)
          flag_mismatch($sformatf("pixel_out %h, want %h", pixel_out_o, want.pixel));
        if (src_x_o !== want.sx)
          flag_mismatch($sformatf("src_x %0d, want %0d", src_x_o, want.sx));
        if (src_y_o !== want.sy)
          flag_mismatch($sformatf("src_y %0d, want %0d", src_y_o, want.sy));
        if (in_range_o !== want.in_range)
          flag_mismatch($sformatf("in_range %b, want %b", in_range_o, want.in_range));
      end
    end
  end

  function automatic int frame_width();
    return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
  endfunction

  function automatic int frame_height();
    return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
  endfunction

  function automatic int scaled_extent(input int dim);
    return (dim * scale_reg) >> FRAC_BITS;
  endfunction

  function automatic sample_t predict_sample(input int x, input int y, output bit loaded);
    sample_t s;
    int      w;
    int      h;
    int      sx;
    int      sy;
    int      idx;
    w      = frame_width();
    h      = frame_height();
    s      = '0;
    loaded = 1'b1;
    if (scale_reg != 0 && x < scaled_extent(w) && y < scaled_extent(h)) begin
      sx = (x << FRAC_BITS) / scale_reg;
      sy = (y << FRAC_BITS) / scale_reg;
      if (sx >= w) sx = w - 1;
      if (sy >= h) sy = h - 1;
      idx        = sy * w + sx;
      loaded     = (idx < frame_ptr);
      s.pixel    = frame_mem[idx];
      s.sx       = sx[SRC_OUT_W-1:0];
      s.sy       = sy[SRC_OUT_W-1:0];
      s.in_range = 1'b1;
    end
    return s;
  endfunction

  task automatic send_request(input opcode_e op, input logic [PIX_W-1:0] pix,
                              input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    start      = 1'b1;
    opcode_i   = op;
    pixel_in_i = pix;
    out_x_i    = x;
    out_y_i    = y;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_pixel(input logic [PIX_W-1:0] pix);
    int total;
    total = frame_width() * frame_height();
    send_request(OP_LOAD, pix, COORD_W'($urandom), COORD_W'($urandom));
    if (frame_ptr < total) begin
      frame_mem[frame_ptr] = pix;
      frame_ptr++;
    end
  endtask

  task automatic read_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    sample_t s;
    bit      loaded;
    s = predict_sample(x, y, loaded);
    // steer away from entries never loaded
    if (!loaded) begin
      x = COORD_FAR;
      s = predict_sample(x, y, loaded);
    end
    send_request(OP_READ, $urandom, x, y);
    expected_samples.push_back(s);
  endtask

  task automatic random_read();
    int                 out_w;
    int                 out_h;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    sample_t            s;
    bit                 loaded;
    out_w = scaled_extent(frame_width());
    out_h = scaled_extent(frame_height());
    for (int tries = 0; tries < 4; tries++) begin
      if (out_w == 0 || out_h == 0 || $urandom_range(0, 4) == 0) begin
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
      end else begin
        x = COORD_W'($urandom_range(0, out_w - 1));
        y = COORD_W'($urandom_range(0, out_h - 1));
      end
      s = predict_sample(x, y, loaded);
      if (loaded) break;
    end
    read_pixel(x, y);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_SRC_WIDTH:  width_reg  = data[DIM_W-1:0];
      CFG_SRC_HEIGHT: height_reg = data[DIM_W-1:0];
      CFG_SCALE_Q:    scale_reg  = data;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (expected_samples.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_frame(input int w, input int h, input int q);
    wait_idle();
    cfg_write(CFG_SRC_WIDTH, CFG_DATA_W'(w));
    cfg_write(CFG_SRC_HEIGHT, CFG_DATA_W'(h));
    cfg_write(CFG_SCALE_Q, CFG_DATA_W'(q));
  endtask

  task automatic test_reset_state();
    read_pixel(12'd256, 12'd0);
    read_pixel(12'd0, 12'd256);
    read_pixel(COORD_FAR, COORD_FAR);
  endtask

  task automatic test_small_frame();
    set_frame(4, 2, SCALE_ONE);
    load_pixel(32'h0000_0000);
    load_pixel(32'hFFFF_FFFF);
    load_pixel(32'hAAAA_AAAA);
    load_pixel(32'h5555_5555);
    repeat (5) load_pixel($urandom);
    read_pixel(12'd0, 12'd0);
    read_pixel(12'd3, 12'd1);
    read_pixel(12'd4, 12'd0);
    read_pixel(12'd0, 12'd2);
  endtask

  task automatic test_scale_extremes();
    set_frame(4, 2, 16'd8192);
    read_pixel(12'd7, 12'd3);
    read_pixel(12'd8, 12'd0);
    set_frame(4, 2, 16'hFFFF);
    read_pixel(12'd62, 12'd30);
    read_pixel(12'd63, 12'd0);
    set_frame(4, 2, 16'd2048);
    read_pixel(12'd1, 12'd0);
    set_frame(4, 2, 16'd1);
    read_pixel(12'd0, 12'd0);
    set_frame(4, 2, 16'd0);
    read_pixel(12'd0, 12'd0);
  endtask

  task automatic test_frame_limits();
    set_frame(0, 2, SCALE_ONE);
    load_pixel($urandom);
    read_pixel(12'd0, 12'd0);
    set_frame(16'hFE00 | 16'd511, 1, SCALE_ONE);
    repeat (3) load_pixel($urandom);
    read_pixel(12'd10, 12'd0);
    read_pixel(12'd255, 12'd0);
    set_frame(1, 256, SCALE_ONE);
    cfg_write(CFG_UNUSED, 16'hFFFF);
    read_pixel(12'd0, 12'd5);
    set_frame(256, 0, SCALE_ONE);
    read_pixel(12'd0, 12'd0);
  endtask

  task automatic pick_dim(output int d);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8)       d = 256;
    else if (roll < 12) d = $urandom_range(257, 511) | ($urandom_range(0, 127) << DIM_W);
    else if (roll < 15) d = 0;
    else if (roll < 22) d = 1;
    else                d = $urandom_range(2, 24);
  endtask

  task automatic test_random_frames(input int idle_pct);
    int w;
    int h;
    int q;
    int roll;
    int fill;
    gap_pct = idle_pct;
    repeat (SEGMENTS) begin
      pick_dim(w);
      pick_dim(h);
      roll = $urandom_range(0, 99);
      if (roll < 10)      q = SCALE_ONE;
      else if (roll < 14) q = 0;
      else if (roll < 18) q = 16'hFFFF;
      else if (roll < 22) q = 1;
      else if (roll < 32) q = $urandom_range(0, 16'hFFFF);
      else                q = $urandom_range(1024, 16384);
      set_frame(w, h, q);
      fill = frame_width() * frame_height() - frame_ptr;
      if (fill > FILL_MAX) fill = FILL_MAX;
      repeat (fill) load_pixel($urandom);
      repeat (MIXED_ITEMS) begin
        if ($urandom_range(0, 3) == 0) load_pixel($urandom);
        else random_read();
      end
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_SRC_WIDTH;
    cfg_data_i = '0;
    start      = 1'b0;
    opcode_i   = OP_LOAD;
    pixel_in_i = '0;
    out_x_i    = '0;
    out_y_i    = '0;
    frame_ptr  = 0;
    width_reg  = RST_WIDTH;
    height_reg = RST_HEIGHT;
    scale_reg  = RST_SCALE;
    err_count  = 0;
    gap_pct    = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_small_frame();
    test_scale_extremes();
    test_frame_limits();
    test_random_frames(0);
    test_random_frames(55);
    test_random_frames(8);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_samples.size() != 0)
      flag_mismatch($sformatf("%0d reads never answered", expected_samples.size()));
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
